### design/aesk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesk_pkg
// Shared tables and helpers for the AES-128 round key expansion pipeline.
// ----------------------------------------------------------------------------
package aesk_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned HalfW = 64;
  localparam int unsigned RoundW = 4;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [RoundW-1:0] round_t;

  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam byte_t RCON [16] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
    8'h80, 8'h1b, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic byte_t sbox(input byte_t x);
    return SBOX[x];
  endfunction

  // Round numbers outside 1..10 map to a zero constant.
  function automatic byte_t rcon(input round_t rn);
    return RCON[rn];
  endfunction

endpackage

### design/aesk_sub_word.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesk_sub_word
// RotWord followed by SubWord and the round constant, registered.
// ----------------------------------------------------------------------------
module aesk_sub_word
  import aesk_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  word_t  w_in,
  input  byte_t  rc_in,
  output word_t  t_out
);

  word_t rot;
  word_t t_nxt;
  word_t t_r;

  assign rot = {w_in[WordW-ByteW-1:0], w_in[WordW-1:WordW-ByteW]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      t_nxt[b*ByteW +: ByteW] = sbox(rot[b*ByteW +: ByteW]);
    end
    t_nxt[WordW-1:WordW-ByteW] = t_nxt[WordW-1:WordW-ByteW] ^ rc_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  assign t_out = t_r;

endmodule

### design/aes128_round_key_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_round_key_expand
// One step of the AES-128 key schedule as a four stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_key_high, in_key_low and in_round_number and raise start. The
//   word is taken at every rising edge where start is high and busy is low.
//   busy is high only while rst_n is low, so a new word may enter every cycle.
//   Stage 1 registers the inputs and the round constant, stage 2 computes the
//   S-box of the rotated last word, stage 3 chains the first two words and
//   stage 4 the last two into the output register.
//   out_valid is high for a single cycle once stage 4 has registered the word,
//   with out_next_key_high and out_next_key_low. The throughput is one word
//   per cycle.
//   The receiver cannot stall; every result is shown for exactly one cycle.
//   A synchronous reset empties the pipeline; words in flight are dropped.
// ----------------------------------------------------------------------------
module aes128_round_key_expand
  import aesk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [HalfW-1:0]  in_key_high,
  input  logic [HalfW-1:0]  in_key_low,
  input  logic [RoundW-1:0] in_round_number,
  output logic              out_valid,
  output logic [HalfW-1:0]  out_next_key_high,
  output logic [HalfW-1:0]  out_next_key_low
);

  logic [3:0] vld_r;
  logic [3:0] vld_nxt;

  word_t s1_w0_r, s1_w1_r, s1_w2_r, s1_w3_r;
  byte_t s1_rc_r;
  word_t s2_w0_r, s2_w1_r, s2_w2_r, s2_w3_r;
  word_t s2_t;
  word_t s3_w0_r, s3_w1_r, s3_w2_r, s3_w3_r;
  word_t s3_w0_nxt, s3_w1_nxt;
  word_t s4_w2_nxt, s4_w3_nxt;
  logic [HalfW-1:0] hi_r, lo_r;

  assign busy = ~rst_n;
  assign vld_nxt = {vld_r[2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: input capture and round constant lookup.
  always_ff @(posedge clk) begin
    if (vld_nxt[0]) begin
      s1_w0_r <= in_key_high[HalfW-1:WordW];
      s1_w1_r <= in_key_high[WordW-1:0];
      s1_w2_r <= in_key_low[HalfW-1:WordW];
      s1_w3_r <= in_key_low[WordW-1:0];
      s1_rc_r <= rcon(in_round_number);
    end
  end

  // Stage 2: S-box of the rotated last word.
  aesk_sub_word u_sub (
    .clk   (clk),
    .en    (vld_nxt[1]),
    .w_in  (s1_w3_r),
    .rc_in (s1_rc_r),
    .t_out (s2_t)
  );

  always_ff @(posedge clk) begin
    if (vld_nxt[1]) begin
      s2_w0_r <= s1_w0_r;
      s2_w1_r <= s1_w1_r;
      s2_w2_r <= s1_w2_r;
      s2_w3_r <= s1_w3_r;
    end
  end

  // Stage 3: first half of the word chain.
  assign s3_w0_nxt = s2_w0_r ^ s2_t;
  assign s3_w1_nxt = s2_w1_r ^ s3_w0_nxt;

  always_ff @(posedge clk) begin
    if (vld_nxt[2]) begin
      s3_w0_r <= s3_w0_nxt;
      s3_w1_r <= s3_w1_nxt;
      s3_w2_r <= s2_w2_r;
      s3_w3_r <= s2_w3_r;
    end
  end

  // Stage 4: second half of the chain into the output register.
  assign s4_w2_nxt = s3_w2_r ^ s3_w1_r;
  assign s4_w3_nxt = s3_w3_r ^ s4_w2_nxt;

  always_ff @(posedge clk) begin
    if (vld_nxt[3]) begin
      hi_r <= {s3_w0_r, s3_w1_r};
      lo_r <= {s4_w2_nxt, s4_w3_nxt};
    end
  end

  assign out_valid         = vld_r[3];
  assign out_next_key_high = hi_r;
  assign out_next_key_low  = lo_r;

endmodule

### design/aesk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesk_checker
// Port level checks for the round key expansion pipeline.
// ----------------------------------------------------------------------------
module aesk_checker
  import aesk_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [HalfW-1:0]  in_key_high,
  input logic [HalfW-1:0]  in_key_low,
  input logic [RoundW-1:0] in_round_number,
  input logic              out_valid,
  input logic [HalfW-1:0]  out_next_key_high,
  input logic [HalfW-1:0]  out_next_key_low
);

  // Every accepted word comes out with out_valid.
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted word did not produce a result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an accepted word");

  // The chain is invertible: adjacent output words XOR back to input words.
  a_w1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_next_key_high[HalfW-1:WordW] ^ out_next_key_high[WordW-1:0])
                   == $past(in_key_high[WordW-1:0], 4)))
    else $error("second key word mismatch");

  a_w2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_next_key_high[WordW-1:0] ^ out_next_key_low[HalfW-1:WordW])
                   == $past(in_key_low[HalfW-1:WordW], 4)))
    else $error("third key word mismatch");

  a_w3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_next_key_low[HalfW-1:WordW] ^ out_next_key_low[WordW-1:0])
                   == $past(in_key_low[WordW-1:0], 4)))
    else $error("fourth key word mismatch");

endmodule

bind aes128_round_key_expand aesk_checker u_aesk_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-128 round key expansion step. Words are
// sent through the start/busy handshake and each key that comes out on
// out_valid is compared with a key schedule step computed here from the
// GF(2^8) definition of the S-box and the round constants.
// ----------------------------------------------------------------------------
module tb;
  import aesk_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned MaxGap = 50;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
  } round_key_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [HalfW-1:0] in_key_high;
  logic [HalfW-1:0] in_key_low;
  round_t in_round_number;
  logic out_valid;
  logic [HalfW-1:0] out_next_key_high;
  logic [HalfW-1:0] out_next_key_low;

  byte_t sub_table [256];
  round_key_t pending_keys [$];
  int sender_idle_pct = 0;
  int words_sent = 0;
  int keys_checked = 0;
  int mismatch_count = 0;
  int unsigned stall_cycles = 0;

  aes128_round_key_expand uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_key_high(in_key_high),
    .in_key_low(in_key_low),
    .in_round_number(in_round_number),
    .out_valid(out_valid),
    .out_next_key_high(out_next_key_high),
    .out_next_key_low(out_next_key_low)
  );

  always #10 clk = ~clk;

  function automatic byte_t gf_double(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = gf_double(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic byte_t rot_byte(input byte_t b, input int n);
    return byte_t'((b << n) | (b >> (8 - n)));
  endfunction

  // The S-box is the multiplicative inverse followed by the affine map.
  function automatic void build_sub_table();
    byte_t inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(byte_t'(x), byte_t'(y)) == 8'h01) inv = byte_t'(y);
      end
      sub_table[x] = inv ^ rot_byte(inv, 1) ^ rot_byte(inv, 2) ^ rot_byte(inv, 3)
                     ^ rot_byte(inv, 4) ^ 8'h63;
    end
  endfunction

  function automatic byte_t round_const(input round_t rn);
    byte_t c;
    if (rn < 1 || rn > 10) return 8'h00;
    c = 8'h01;
    for (int i = 1; i < rn; i++) c = gf_double(c);
    return c;
  endfunction

  function automatic round_key_t next_round_key(input logic [HalfW-1:0] hi,
                                                input logic [HalfW-1:0] lo,
                                                input round_t rn);
    word_t w0, w1, w2, w3, rot, t;
    round_key_t nk;
    w0 = hi[63:32];
    w1 = hi[31:0];
    w2 = lo[63:32];
    w3 = lo[31:0];
    rot = {w3[23:0], w3[31:24]};
    t = {sub_table[rot[31:24]], sub_table[rot[23:16]],
         sub_table[rot[15:8]], sub_table[rot[7:0]]};
    t[31:24] ^= round_const(rn);
    w0 ^= t;
    w1 ^= w0;
    w2 ^= w1;
    w3 ^= w2;
    nk.hi = {w0, w1};
    nk.lo = {w2, w3};
    return nk;
  endfunction

  // Sends one word after a random idle gap and records the key it must give.
  task automatic send_word(input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo,
                           input round_t rn);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      in_key_high <= {$urandom, $urandom};
      in_key_low <= {$urandom, $urandom};
      in_round_number <= round_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_key_high <= hi;
    in_key_low <= lo;
    in_round_number <= rn;
    do @(posedge clk); while (busy !== 1'b0);
    pending_keys.push_back(next_round_key(hi, lo, rn));
    words_sent++;
  endtask

  // Every round number, each on one of the extreme key patterns.
  task automatic test_round_constants();
    logic [HalfW-1:0] pattern;
    for (int rn = 0; rn < 16; rn++) begin
      case (rn % 4)
        0: pattern = '0;
        1: pattern = '1;
        2: pattern = {(HalfW/2){2'b10}};
        default: pattern = {(HalfW/2){2'b01}};
      endcase
      send_word(pattern, ~pattern ^ {HalfW{rn[0]}}, round_t'(rn));
    end
  endtask

  // The published AES-128 schedule; the last round key also checks the
  // prediction itself.
  task automatic test_known_schedule();
    round_key_t k;
    k.hi = 64'h2b7e151628aed2a6;
    k.lo = 64'habf7158809cf4f3c;
    for (int rn = 1; rn <= 10; rn++) begin
      send_word(k.hi, k.lo, round_t'(rn));
      k = next_round_key(k.hi, k.lo, round_t'(rn));
    end
    if (k !== {64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6}) begin
      $display("%0t schedule prediction: expected %h actual %h", $time,
               {64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6}, k);
      mismatch_count++;
    end
  endtask

  // Full ten round schedules from random keys, now and then with a stray
  // round number that breaks the sequence.
  task automatic test_schedule_chains(input int n_chains);
    round_key_t k;
    round_t rn;
    for (int c = 0; c < n_chains; c++) begin
      k = {$urandom, $urandom, $urandom, $urandom};
      for (int r = 1; r <= 10; r++) begin
        rn = ($urandom_range(19) == 0) ? round_t'($urandom) : round_t'(r);
        send_word(k.hi, k.lo, rn);
        k = next_round_key(k.hi, k.lo, rn);
      end
    end
  endtask

  task automatic test_random_words(input int n_words);
    for (int i = 0; i < n_words; i++) begin
      send_word({$urandom, $urandom}, {$urandom, $urandom}, round_t'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_keys.size() == 0) begin
        $display("%0t unexpected key: expected none actual %h %h", $time,
                 out_next_key_high, out_next_key_low);
        mismatch_count++;
      end else begin
        round_key_t exp_key;
        exp_key = pending_keys.pop_front();
        if (out_next_key_high !== exp_key.hi) begin
          $display("%0t next_key_high: expected %h actual %h", $time,
                   exp_key.hi, out_next_key_high);
          mismatch_count++;
        end
        if (out_next_key_low !== exp_key.lo) begin
          $display("%0t next_key_low: expected %h actual %h", $time,
                   exp_key.lo, out_next_key_low);
          mismatch_count++;
        end
        keys_checked++;
      end
    end else if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      $display("%0t out_valid: expected 0 or 1 actual %b", $time, out_valid);
      mismatch_count++;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t watchdog: nothing moved for %0d cycles, %0d keys still due",
               $time, StallLimit, pending_keys.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_key_high <= '0;
    in_key_low <= '0;
    in_round_number <= '0;
    build_sub_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 18;
    test_round_constants();
    test_known_schedule();
    test_schedule_chains(20);
    test_random_words(80);

    sender_idle_pct = 80;
    test_schedule_chains(20);
    test_random_words(80);

    sender_idle_pct = 0;
    test_schedule_chains(20);
    test_random_words(80);

    start <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d words and checked %0d keys: all round numbers, extreme keys,",
             words_sent, keys_checked);
    $display("the published schedule, random schedules and random words at three idle rates.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
